// ===== rtl/vliu_pkg.sv =====
// Package for the view list interest update core.
// Types, codes and helper functions shared by the core, its units and the checker.
package vliu_pkg;

    localparam int MAX_PLAYERS = 32;
    localparam int SLOT_BITS   = $clog2(MAX_PLAYERS);
    localparam int COORD_BITS  = 10;
    localparam int SIZE_BITS   = COORD_BITS + 1;
    localparam int STAMP_BITS  = 32;
    localparam int SQ_BITS     = 2 * COORD_BITS;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 64;

    // event kinds
    localparam logic [1:0] KIND_ENTER = 2'd0;
    localparam logic [1:0] KIND_MOVE  = 2'd1;
    localparam logic [1:0] KIND_LEAVE = 2'd2;

    // notice codes
    localparam logic [1:0] NTC_LOGIN  = 2'd0;
    localparam logic [1:0] NTC_ADD    = 2'd1;
    localparam logic [1:0] NTC_MOVE   = 2'd2;
    localparam logic [1:0] NTC_REMOVE = 2'd3;

    // move directions
    localparam logic [1:0] DIR_Y_DOWN = 2'd0;
    localparam logic [1:0] DIR_Y_UP   = 2'd1;
    localparam logic [1:0] DIR_X_DOWN = 2'd2;
    localparam logic [1:0] DIR_X_UP   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RANGE  = 2'd2;

    typedef logic [MAX_PLAYERS-1:0] map_t;

    typedef struct packed {
        logic [STAMP_BITS-1:0] stamp;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
        logic                  game;
    } slot_t;

    typedef struct packed {
        logic [4:0]            rcp;
        logic [1:0]            ntc;
        logic [4:0]            subj;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic [STAMP_BITS-1:0] st;
    } note_t;

    // largest coordinate for a world size; zero means one, capped at 2^COORD_BITS
    function automatic logic [COORD_BITS-1:0] max_coord(input logic [SIZE_BITS-1:0] size);
        logic [SIZE_BITS-1:0] s;
        s = size;
        if (s == '0)
        begin
            s = SIZE_BITS'(1);
        end
        if (s > SIZE_BITS'(1 << COORD_BITS))
        begin
            s = SIZE_BITS'(1 << COORD_BITS);
        end
        return COORD_BITS'(s - SIZE_BITS'(1));
    endfunction

    function automatic note_t make_note(
        input logic [4:0]            rcp,
        input logic [1:0]            ntc,
        input logic [4:0]            subj,
        input logic [COORD_BITS-1:0] px,
        input logic [COORD_BITS-1:0] py,
        input logic [STAMP_BITS-1:0] st
    );
        note_t n;
        n.rcp  = rcp;
        n.ntc  = ntc;
        n.subj = subj;
        n.px   = (ntc == NTC_REMOVE) ? '0 : px;
        n.py   = (ntc == NTC_REMOVE) ? '0 : py;
        n.st   = (ntc == NTC_MOVE) ? st : '0;
        return n;
    endfunction

endpackage

// ===== rtl/vliu_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module vliu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/vliu_dist.sv =====
// Visibility unit: registered squared deltas, then sum and compare to range squared.
// Uses vliu_pkg.
module vliu_dist (
    input  logic                                clk,
    input  logic                                en,
    input  logic [vliu_pkg::COORD_BITS-1:0]     ax,
    input  logic [vliu_pkg::COORD_BITS-1:0]     ay,
    input  logic [vliu_pkg::COORD_BITS-1:0]     bx,
    input  logic [vliu_pkg::COORD_BITS-1:0]     by,
    input  logic [vliu_pkg::SQ_BITS-1:0]        rr,
    output logic                                vis
);

    logic [vliu_pkg::COORD_BITS-1:0] dx;
    logic [vliu_pkg::COORD_BITS-1:0] dy;
    logic [vliu_pkg::SQ_BITS-1:0]    dx2_reg;
    logic [vliu_pkg::SQ_BITS-1:0]    dy2_reg;

    assign dx = (ax > bx) ? (ax - bx) : (bx - ax);
    assign dy = (ay > by) ? (ay - by) : (by - ay);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx2_reg <= dx * dx;
            dy2_reg <= dy * dy;
        end
    end

    assign vis = ({1'b0, dx2_reg} + {1'b0, dy2_reg}) <= {1'b0, rr};

endmodule

// ===== rtl/view_list_interest_update_core.sv =====
// Top level of the view list interest update core.
// Uses vliu_pkg, vliu_ram (slot table and view maps) and vliu_dist.
//
// Usage:
//   Input channel s_*: one beat is one event (enter, move, leave) for one slot.
//   Output channel m_*: one beat is one notice; m_tlast marks the final notice
//   of an event. Events that cause nothing (bad kind, enter on a slot in game,
//   move/leave on a free slot) produce no beats.
//   cfg_we/cfg_index/cfg_data write world width, height and view range; write
//   only while the core is idle.
// Sequencing:
//   One event at a time. Accept and acting-slot load come first, then the
//   first notice (none for leave). Each other slot is then visited in turn
//   (read, data, decide, two notice slots, advance), the acting slot's own
//   index is skipped, and finish and flush end the event. s_tready is high
//   only between events.
// Reset:
//   Slot table reads as all free, zero position/stamp, empty view maps; a
//   valid bit per RAM entry covers entries never written. Config returns to
//   1024 x 1024, range 5.
// Stall:
//   Notices pass through a one-deep hold register and the output register;
//   when m_tready is low with a beat held, the walk waits at the next notice.
module view_list_interest_update_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // player[4:0] start_x[14:5] start_y[24:15]
                                   // direction[26:25] stamp[58:27] zero[63:59]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // recipient[4:0] subject[9:5] pos_x[19:10]
                                   // pos_y[29:20] move_stamp[61:30] zero[63:62]
    output logic [1:0]  m_tuser,   // notice[1:0]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int SB = vliu_pkg::SLOT_BITS;
    localparam int CB = vliu_pkg::COORD_BITS;
    localparam int NP = vliu_pkg::MAX_PLAYERS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOADC = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_WAIT  = 4'd3;
    localparam logic [3:0] S_DEC   = 4'd4;
    localparam logic [3:0] S_E1    = 4'd5;
    localparam logic [3:0] S_E2    = 4'd6;
    localparam logic [3:0] S_ADV   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_FLUSH = 4'd9;

    logic [3:0] state_reg;

    // config
    logic [vliu_pkg::SIZE_BITS-1:0] width_reg;
    logic [vliu_pkg::SIZE_BITS-1:0] height_reg;
    logic [CB-1:0]                  range_reg;

    // event registers
    logic [1:0]                     kind_reg;
    logic [4:0]                     player_reg;
    logic [CB-1:0]                  sx_reg;
    logic [CB-1:0]                  sy_reg;
    logic [1:0]                     dir_reg;
    logic [vliu_pkg::STAMP_BITS-1:0] stin_reg;

    logic [CB-1:0]                  cx_reg;
    logic [CB-1:0]                  cy_reg;
    logic [vliu_pkg::STAMP_BITS-1:0] cst_reg;
    vliu_pkg::map_t                 cmap_reg;
    vliu_pkg::map_t                 oldmap_reg;
    logic [vliu_pkg::SQ_BITS-1:0]   rr_reg;
    logic [SB-1:0]                  j_reg;
    logic                           start_reg;

    vliu_pkg::slot_t                jrec_reg;
    vliu_pkg::map_t                 jmap_reg;

    vliu_pkg::note_t                e1_reg;
    vliu_pkg::note_t                e2_reg;
    logic                           e1v_reg;
    logic                           e2v_reg;

    vliu_pkg::note_t                pend_reg;
    logic                           pend_v_reg;
    vliu_pkg::note_t                out_reg;
    logic                           out_last_reg;
    logic                           out_v_reg;

    // RAM valid bits (entry never written reads as reset value)
    logic [NP-1:0]                  slot_vld_reg;
    logic [NP-1:0]                  map_vld_reg;
    logic                           rslot_vld_reg;
    logic                           rmap_vld_reg;

    // RAM ports
    logic [SB-1:0]                  rd_addr;
    logic                           slot_we;
    logic [SB-1:0]                  slot_waddr;
    vliu_pkg::slot_t                slot_wdata;
    vliu_pkg::slot_t                slot_q;
    vliu_pkg::slot_t                slot_rd;
    logic                           map_we;
    logic [SB-1:0]                  map_waddr;
    vliu_pkg::map_t                 map_wdata;
    vliu_pkg::map_t                 map_q;
    vliu_pkg::map_t                 map_rd;

    logic [SB-1:0]                  c_idx;
    logic [SB-1:0]                  in_idx;
    logic                           can_push;
    logic                           vis;

    // acting-slot load decode
    logic                           load_ok;
    logic [CB-1:0]                  mx;
    logic [CB-1:0]                  my;
    vliu_pkg::slot_t                cnew;
    vliu_pkg::note_t                first_note;

    // per-slot decision
    vliu_pkg::note_t                e1_next;
    vliu_pkg::note_t                e2_next;
    logic                           e1v_next;
    logic                           e2v_next;
    vliu_pkg::map_t                 jmap_next;
    vliu_pkg::map_t                 cmap_next;

    assign c_idx    = player_reg[SB-1:0];
    assign in_idx   = s_tdata[SB-1:0];
    assign can_push = !out_v_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    assign rd_addr  = (state_reg == S_IDLE) ? in_idx : j_reg;
    assign slot_rd  = rslot_vld_reg ? slot_q : '0;
    assign map_rd   = rmap_vld_reg ? map_q : '0;

    vliu_ram #(
        .WIDTH($bits(vliu_pkg::slot_t)),
        .DEPTH(NP)
    ) u_slot_ram (
        .clk  (clk),
        .we   (slot_we),
        .waddr(slot_waddr),
        .wdata(slot_wdata),
        .raddr(rd_addr),
        .rdata(slot_q)
    );

    vliu_ram #(
        .WIDTH(NP),
        .DEPTH(NP)
    ) u_map_ram (
        .clk  (clk),
        .we   (map_we),
        .waddr(map_waddr),
        .wdata(map_wdata),
        .raddr(rd_addr),
        .rdata(map_q)
    );

    // distance check between the acting slot and the slot being read
    vliu_dist u_dist (
        .clk(clk),
        .en (state_reg == S_WAIT),
        .ax (cx_reg),
        .ay (cy_reg),
        .bx (slot_rd.x),
        .by (slot_rd.y),
        .rr (rr_reg),
        .vis(vis)
    );

    // acting slot: validity and new record
    always_comb
    begin
        mx = vliu_pkg::max_coord(width_reg);
        my = vliu_pkg::max_coord(height_reg);
        cnew = slot_rd;
        load_ok = 1'b0;
        unique case (kind_reg)
            vliu_pkg::KIND_ENTER:
            begin
                load_ok   = !slot_rd.game;
                cnew.x    = (sx_reg > mx) ? mx : sx_reg;
                cnew.y    = (sy_reg > my) ? my : sy_reg;
                cnew.game = 1'b1;
            end
            vliu_pkg::KIND_MOVE:
            begin
                load_ok    = slot_rd.game;
                cnew.stamp = stin_reg;
                unique case (dir_reg)
                    vliu_pkg::DIR_Y_DOWN:
                    begin
                        if (slot_rd.y > '0) cnew.y = slot_rd.y - CB'(1);
                    end
                    vliu_pkg::DIR_Y_UP:
                    begin
                        if (slot_rd.y < my) cnew.y = slot_rd.y + CB'(1);
                    end
                    vliu_pkg::DIR_X_DOWN:
                    begin
                        if (slot_rd.x > '0) cnew.x = slot_rd.x - CB'(1);
                    end
                    vliu_pkg::DIR_X_UP:
                    begin
                        if (slot_rd.x < mx) cnew.x = slot_rd.x + CB'(1);
                    end
                    default:
                    begin
                        cnew.x = slot_rd.x;
                    end
                endcase
            end
            vliu_pkg::KIND_LEAVE:
            begin
                load_ok = slot_rd.game;
            end
            default:
            begin
                load_ok = 1'b0;
            end
        endcase
        if ({1'b0, player_reg} >= 6'(NP))
        begin
            load_ok = 1'b0;
        end
        first_note = vliu_pkg::make_note(player_reg,
            (kind_reg == vliu_pkg::KIND_MOVE) ? vliu_pkg::NTC_MOVE : vliu_pkg::NTC_LOGIN,
            player_reg, cnew.x, cnew.y, cnew.stamp);
    end

    // per-slot notices and map updates
    always_comb
    begin
        logic [4:0] jn;
        logic       nv;
        logic       ov;
        jn        = 5'(j_reg);
        nv        = jrec_reg.game && vis;
        ov        = oldmap_reg[j_reg];
        e1_next   = '0;
        e2_next   = '0;
        e1v_next  = 1'b0;
        e2v_next  = 1'b0;
        jmap_next = jmap_reg;
        cmap_next = cmap_reg;
        unique case (kind_reg)
            vliu_pkg::KIND_ENTER:
            begin
                if (nv)
                begin
                    e1_next  = vliu_pkg::make_note(jn, vliu_pkg::NTC_ADD, player_reg,
                                                   cx_reg, cy_reg, cst_reg);
                    e2_next  = vliu_pkg::make_note(player_reg, vliu_pkg::NTC_ADD, jn,
                                                   jrec_reg.x, jrec_reg.y, jrec_reg.stamp);
                    e1v_next = 1'b1;
                    e2v_next = 1'b1;
                    jmap_next[c_idx] = 1'b1;
                    cmap_next[j_reg] = 1'b1;
                end
            end
            vliu_pkg::KIND_MOVE:
            begin
                priority if (nv && !ov)
                begin
                    e1_next  = vliu_pkg::make_note(player_reg, vliu_pkg::NTC_ADD, jn,
                                                   jrec_reg.x, jrec_reg.y, jrec_reg.stamp);
                    e2_next  = vliu_pkg::make_note(jn, vliu_pkg::NTC_ADD, player_reg,
                                                   cx_reg, cy_reg, cst_reg);
                    e1v_next = 1'b1;
                    e2v_next = 1'b1;
                    cmap_next[j_reg] = 1'b1;
                    jmap_next[c_idx] = 1'b1;
                end
                else if (nv)
                begin
                    e1_next  = vliu_pkg::make_note(jn, vliu_pkg::NTC_MOVE, player_reg,
                                                   cx_reg, cy_reg, cst_reg);
                    e1v_next = 1'b1;
                end
                else if (ov)
                begin
                    e1_next  = vliu_pkg::make_note(player_reg, vliu_pkg::NTC_REMOVE, jn,
                                                   jrec_reg.x, jrec_reg.y, jrec_reg.stamp);
                    e2_next  = vliu_pkg::make_note(jn, vliu_pkg::NTC_REMOVE, player_reg,
                                                   cx_reg, cy_reg, cst_reg);
                    e1v_next = 1'b1;
                    e2v_next = 1'b1;
                    cmap_next[j_reg] = 1'b0;
                    jmap_next[c_idx] = 1'b0;
                end
                else
                begin
                    e1v_next = 1'b0;
                end
            end
            default:
            begin
                // leave: tell every other slot in game
                if (jrec_reg.game)
                begin
                    e1_next  = vliu_pkg::make_note(jn, vliu_pkg::NTC_REMOVE, player_reg,
                                                   cx_reg, cy_reg, cst_reg);
                    e1v_next = 1'b1;
                    jmap_next[c_idx] = 1'b0;
                end
            end
        endcase
    end

    // RAM write ports
    always_comb
    begin
        slot_we    = 1'b0;
        slot_waddr = c_idx;
        slot_wdata = cnew;
        map_we     = 1'b0;
        map_waddr  = j_reg;
        map_wdata  = jmap_next;
        unique case (state_reg)
            S_LOADC:
            begin
                slot_we = load_ok && (kind_reg != vliu_pkg::KIND_LEAVE);
            end
            S_DEC:
            begin
                map_we = 1'b1;
            end
            S_FIN:
            begin
                map_we    = 1'b1;
                map_waddr = c_idx;
                map_wdata = (kind_reg == vliu_pkg::KIND_LEAVE) ? '0 : cmap_reg;
                slot_we   = (kind_reg == vliu_pkg::KIND_LEAVE);
                slot_wdata.stamp = cst_reg;
                slot_wdata.y     = cy_reg;
                slot_wdata.x     = cx_reg;
                slot_wdata.game  = 1'b0;
            end
            default:
            begin
                slot_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= vliu_pkg::SIZE_BITS'(1024);
            height_reg    <= vliu_pkg::SIZE_BITS'(1024);
            range_reg     <= CB'(5);
            slot_vld_reg  <= '0;
            map_vld_reg   <= '0;
            rslot_vld_reg <= 1'b0;
            rmap_vld_reg  <= 1'b0;
            pend_v_reg    <= 1'b0;
            out_v_reg     <= 1'b0;
            e1v_reg       <= 1'b0;
            e2v_reg       <= 1'b0;
            start_reg     <= 1'b0;
            j_reg         <= '0;
        end
        else
        begin
            logic            push;
            vliu_pkg::note_t pnote;
            push  = 1'b0;
            pnote = e1_reg;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    vliu_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                    vliu_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                    vliu_pkg::CFG_RANGE:  range_reg  <= cfg_data[CB-1:0];
                    default:              range_reg  <= range_reg;
                endcase
            end

            rslot_vld_reg <= slot_vld_reg[rd_addr];
            rmap_vld_reg  <= map_vld_reg[rd_addr];
            if (slot_we) slot_vld_reg[slot_waddr] <= 1'b1;
            if (map_we)  map_vld_reg[map_waddr]   <= 1'b1;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        kind_reg   <= s_tuser;
                        player_reg <= s_tdata[4:0];
                        sx_reg     <= s_tdata[14:5];
                        sy_reg     <= s_tdata[24:15];
                        dir_reg    <= s_tdata[26:25];
                        stin_reg   <= s_tdata[58:27];
                        state_reg  <= S_LOADC;
                    end
                end
                S_LOADC:
                begin
                    cx_reg     <= cnew.x;
                    cy_reg     <= cnew.y;
                    cst_reg    <= cnew.stamp;
                    cmap_reg   <= (kind_reg == vliu_pkg::KIND_ENTER) ? '0 : map_rd;
                    oldmap_reg <= map_rd;
                    rr_reg     <= range_reg * range_reg;
                    j_reg      <= '0;
                    e1_reg     <= first_note;
                    e1v_reg    <= 1'b1;
                    e2v_reg    <= 1'b0;
                    // leave has no first notice and starts the walk directly
                    start_reg  <= (kind_reg != vliu_pkg::KIND_LEAVE);
                    priority if (!load_ok)
                        state_reg <= S_IDLE;
                    else if (kind_reg == vliu_pkg::KIND_LEAVE)
                        state_reg <= S_RD;
                    else
                        state_reg <= S_E1;
                end
                S_RD:
                begin
                    state_reg <= (j_reg == c_idx) ? S_ADV : S_WAIT;
                end
                S_WAIT:
                begin
                    jrec_reg  <= slot_rd;
                    jmap_reg  <= map_rd;
                    state_reg <= S_DEC;
                end
                S_DEC:
                begin
                    e1_reg    <= e1_next;
                    e2_reg    <= e2_next;
                    e1v_reg   <= e1v_next;
                    e2v_reg   <= e2v_next;
                    cmap_reg  <= cmap_next;
                    state_reg <= S_E1;
                end
                S_E1:
                begin
                    if (!e1v_reg)
                        state_reg <= S_E2;
                    else if (can_push)
                    begin
                        push      = 1'b1;
                        pnote     = e1_reg;
                        state_reg <= S_E2;
                    end
                end
                S_E2:
                begin
                    if (!e2v_reg || can_push)
                    begin
                        push      = e2v_reg;
                        pnote     = e2_reg;
                        start_reg <= 1'b0;
                        state_reg <= start_reg ? S_RD : S_ADV;
                    end
                end
                S_ADV:
                begin
                    if (j_reg == SB'(NP - 1))
                        state_reg <= S_FIN;
                    else
                    begin
                        j_reg     <= j_reg + SB'(1);
                        state_reg <= S_RD;
                    end
                end
                S_FIN:
                begin
                    state_reg <= S_FLUSH;
                end
                S_FLUSH:
                begin
                    // final notice of the event goes out with tlast
                    if (!pend_v_reg)
                        state_reg <= S_IDLE;
                    else if (can_push)
                    begin
                        out_reg      <= pend_reg;
                        out_last_reg <= 1'b1;
                        pend_v_reg   <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // hold one notice back so the last one can be marked
            if (push)
            begin
                pend_reg   <= pnote;
                pend_v_reg <= 1'b1;
                if (pend_v_reg)
                begin
                    out_reg      <= pend_reg;
                    out_last_reg <= 1'b0;
                end
            end

            if ((push && pend_v_reg) || (state_reg == S_FLUSH && pend_v_reg && can_push))
                out_v_reg <= 1'b1;
            else if (m_tready)
                out_v_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tuser  = out_reg.ntc;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_reg.st, out_reg.py, out_reg.px, out_reg.subj, out_reg.rcp};

endmodule

// ===== rtl/vliu_checker.sv =====
// Port-level checker for the view list interest update core, bound to the top.
// Uses vliu_pkg notice codes.
module vliu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed under stall");

    // remove notices carry no position
    a_rem_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == vliu_pkg::NTC_REMOVE |-> m_tdata[29:10] == 20'd0)
        else $error("remove notice with position");

    // only move notices carry a stamp
    a_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != vliu_pkg::NTC_MOVE |-> m_tdata[61:30] == 32'd0)
        else $error("stamp on non-move notice");

    // login notice goes to the player itself
    a_login: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == vliu_pkg::NTC_LOGIN |-> m_tdata[4:0] == m_tdata[9:5])
        else $error("login notice to another slot");

endmodule

bind view_list_interest_update_core vliu_checker u_vliu_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for view_list_interest_update_core.
// Depends on vliu_pkg; predicts the slot table and view maps in-house and checks every notice.
`timescale 1ns / 100ps

module testbench;

    typedef bit bool_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  player;
        logic [9:0]  sx;
        logic [9:0]  sy;
        logic [1:0]  dir;
        logic [31:0] stamp;
    } event_t;

    typedef struct packed {
        logic [4:0]  rcp;
        logic [1:0]  ntc;
        logic [4:0]  subj;
        logic [9:0]  px;
        logic [9:0]  py;
        logic [31:0] st;
        logic        last;
    } notice_t;

    localparam int WATCHDOG = 20000;
    localparam int DRAIN    = 400;
    localparam int NP       = vliu_pkg::MAX_PLAYERS;

    // event kind with no meaning; the core ignores it
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;

    view_list_interest_update_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow of the block's state
    logic [10:0] w_width;
    logic [10:0] w_rows;
    logic [9:0]  v_range;
    logic        in_game [NP];
    logic [9:0]  pos_x   [NP];
    logic [9:0]  pos_y   [NP];
    logic [31:0] last_st [NP];
    logic [31:0] sees_map[NP];

    notice_t pending_notices[$];
    int      errors;
    int      idle_cycles;
    bool_t   sending_done;
    int      long_hold;       // receiver hold-off request, in cycles

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [9:0] top_coord(input logic [10:0] size);
        logic [10:0] s;
        s = size;
        if (s == 11'd0)
        begin
            s = 11'd1;
        end
        if (s > 11'd1024)
        begin
            s = 11'd1024;
        end
        return 10'(s - 11'd1);
    endfunction

    function automatic bit in_view(input int a, input int b);
        longint dx;
        longint dy;
        longint r;
        dx = pos_x[a] > pos_x[b] ? pos_x[a] - pos_x[b] : pos_x[b] - pos_x[a];
        dy = pos_y[a] > pos_y[b] ? pos_y[a] - pos_y[b] : pos_y[b] - pos_y[a];
        r  = v_range;
        return dx * dx + dy * dy <= r * r;
    endfunction

    // queue one notice and update the recipient's view map
    function automatic void post(input int rcp, input logic [1:0] ntc, input int subj);
        notice_t n;
        n.rcp  = 5'(rcp);
        n.ntc  = ntc;
        n.subj = 5'(subj);
        n.px   = (ntc == vliu_pkg::NTC_REMOVE) ? 10'd0 : pos_x[subj];
        n.py   = (ntc == vliu_pkg::NTC_REMOVE) ? 10'd0 : pos_y[subj];
        n.st   = (ntc == vliu_pkg::NTC_MOVE) ? last_st[subj] : 32'd0;
        n.last = 1'b0;
        if (ntc == vliu_pkg::NTC_ADD)
        begin
            sees_map[rcp][subj] = 1'b1;
        end
        if (ntc == vliu_pkg::NTC_REMOVE)
        begin
            sees_map[rcp][subj] = 1'b0;
        end
        pending_notices.push_back(n);
    endfunction

    // compute the notices one event causes; returns how many
    function automatic int predict_notices(input event_t ev);
        int          c;
        int          base_cnt;
        logic [9:0]  mx;
        logic [9:0]  my;
        logic [31:0] old;
        bit          nv;
        bit          ov;
        notice_t     tail;
        c        = ev.player;
        base_cnt = pending_notices.size();
        mx       = top_coord(w_width);
        my       = top_coord(w_rows);
        if (ev.kind == vliu_pkg::KIND_ENTER)
        begin
            if (in_game[c])
            begin
                return 0;
            end
            pos_x[c]    = ev.sx > mx ? mx : ev.sx;
            pos_y[c]    = ev.sy > my ? my : ev.sy;
            in_game[c]  = 1'b1;
            sees_map[c] = '0;
            post(c, vliu_pkg::NTC_LOGIN, c);
            for (int j = 0; j < NP; j++)
            begin
                if (j != c && in_game[j] && in_view(c, j))
                begin
                    post(j, vliu_pkg::NTC_ADD, c);
                    post(c, vliu_pkg::NTC_ADD, j);
                end
            end
        end
        else if (ev.kind == vliu_pkg::KIND_MOVE)
        begin
            if (!in_game[c])
            begin
                return 0;
            end
            last_st[c] = ev.stamp;
            case (ev.dir)
                vliu_pkg::DIR_Y_DOWN: if (pos_y[c] > 0)  pos_y[c] = pos_y[c] - 1'b1;
                vliu_pkg::DIR_Y_UP:   if (pos_y[c] < my) pos_y[c] = pos_y[c] + 1'b1;
                vliu_pkg::DIR_X_DOWN: if (pos_x[c] > 0)  pos_x[c] = pos_x[c] - 1'b1;
                default:              if (pos_x[c] < mx) pos_x[c] = pos_x[c] + 1'b1;
            endcase
            old = sees_map[c];
            post(c, vliu_pkg::NTC_MOVE, c);
            for (int j = 0; j < NP; j++)
            begin
                if (j != c)
                begin
                    nv = in_game[j] && in_view(c, j);
                    ov = old[j];
                    if (nv && !ov)
                    begin
                        post(c, vliu_pkg::NTC_ADD, j);
                        post(j, vliu_pkg::NTC_ADD, c);
                    end
                    else if (nv)
                    begin
                        post(j, vliu_pkg::NTC_MOVE, c);
                    end
                    else if (ov)
                    begin
                        post(c, vliu_pkg::NTC_REMOVE, j);
                        post(j, vliu_pkg::NTC_REMOVE, c);
                    end
                end
            end
        end
        else if (ev.kind == vliu_pkg::KIND_LEAVE)
        begin
            if (!in_game[c])
            begin
                return 0;
            end
            for (int j = 0; j < NP; j++)
            begin
                if (j != c && in_game[j])
                begin
                    post(j, vliu_pkg::NTC_REMOVE, c);
                end
            end
            in_game[c]  = 1'b0;
            sees_map[c] = '0;
        end
        if (pending_notices.size() > base_cnt)
        begin
            tail = pending_notices.pop_back();
            tail.last = 1'b1;
            pending_notices.push_back(tail);
        end
        return pending_notices.size() - base_cnt;
    endfunction

    // ---------------------------------------------------------------
    // Output side: random stalls, one long hold-off on request
    // ---------------------------------------------------------------
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold > 0)
            begin
                m_tready = 1'b0;
                repeat (long_hold) @(negedge clk);
                long_hold = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 4) == 0)
            begin
                gap = 0;
            end
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            // hold ready until a beat is taken
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // checker: every accepted notice against the oldest expectation
    always @(posedge clk)
    begin
        notice_t got;
        notice_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.rcp  = m_tdata[4:0];
            got.subj = m_tdata[9:5];
            got.px   = m_tdata[19:10];
            got.py   = m_tdata[29:20];
            got.st   = m_tdata[61:30];
            got.ntc  = m_tuser;
            got.last = m_tlast;
            if (pending_notices.size() == 0)
            begin
                $display("%0t: unexpected notice, expected none, got %p", $time, got);
                errors++;
            end
            else
            begin
                want = pending_notices.pop_front();
                if (got !== want)
                begin
                    $display("%0t: notice mismatch, expected %p, got %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with no beat accepted on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n || long_hold > 0)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            vliu_pkg::CFG_WIDTH:  w_width = val;
            vliu_pkg::CFG_HEIGHT: w_rows  = val;
            default:              v_range = val[9:0];
        endcase
    endtask

    // wait until every expected notice has come out, then let the walk finish
    task automatic drain_notices();
        while (pending_notices.size() != 0) @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    // one event beat; expectations are queued when the beat is accepted
    task automatic send_event(input event_t ev);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        repeat (gap) @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = ev.kind;
        s_tdata  = {5'd0, ev.stamp, ev.dir, ev.sy, ev.sx, ev.player};
        do @(posedge clk); while (!s_tready);
        void'(predict_notices(ev));
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    function automatic event_t mk(input logic [1:0] k, input int p, input int x, input int y,
                                  input logic [1:0] d, input logic [31:0] s);
        event_t e;
        e.kind = k; e.player = 5'(p); e.sx = 10'(x); e.sy = 10'(y); e.dir = d; e.stamp = s;
        return e;
    endfunction

    // random event, mostly well-formed against the shadow table
    function automatic event_t rand_event(input int cluster);
        event_t e;
        int     p;
        int     r;
        p = (cluster > 0) ? $urandom_range(0, cluster - 1) : $urandom_range(0, 31);
        r = $urandom_range(0, 99);
        e.player = 5'(p);
        e.sx     = 10'($urandom_range(0, 12));
        e.sy     = 10'($urandom_range(0, 12));
        if ($urandom_range(0, 9) == 0)
        begin
            e.sx = 10'($urandom);
            e.sy = 10'($urandom);
        end
        e.dir   = 2'($urandom);
        e.stamp = $urandom;
        if (r < 4)
        begin
            e.kind = KIND_UNKNOWN;
        end
        else if (!in_game[p])
        begin
            e.kind = (r < 85) ? vliu_pkg::KIND_ENTER : 2'($urandom_range(1, 2));
        end
        else
        begin
            e.kind = (r < 80) ? vliu_pkg::KIND_MOVE :
                     ((r < 92) ? vliu_pkg::KIND_LEAVE : vliu_pkg::KIND_ENTER);
        end
        return e;
    endfunction

    event_t directed_events[$];
    notice_t first_expected[$];

    initial
    begin
        event_t ev;
        int     got_before;
        errors       = 0;
        idle_cycles  = 0;
        long_hold    = 0;
        sending_done = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        cfg_we       = 1'b0;
        cfg_index    = vliu_pkg::CFG_WIDTH;
        cfg_data     = '0;
        w_width      = 11'd1024;
        w_rows       = 11'd1024;
        v_range      = 10'd5;
        for (int i = 0; i < NP; i++)
        begin
            in_game[i] = 1'b0; pos_x[i] = '0; pos_y[i] = '0;
            last_st[i] = '0;   sees_map[i] = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (4) @(negedge clk);

        // directed table: extremes, every kind, ignored cases, saturation
        directed_events = '{
            mk(vliu_pkg::KIND_MOVE,  3, 0, 0, vliu_pkg::DIR_X_UP, 32'd1),   // move on free slot
            mk(vliu_pkg::KIND_LEAVE, 3, 0, 0, vliu_pkg::DIR_Y_DOWN, 0),     // leave on free slot
            mk(KIND_UNKNOWN,         3, 0, 0, vliu_pkg::DIR_Y_DOWN, 0),     // unknown kind
            mk(vliu_pkg::KIND_ENTER, 0, 0, 0, vliu_pkg::DIR_Y_DOWN, 0),     // login only
            mk(vliu_pkg::KIND_ENTER, 31, 1023, 1023, vliu_pkg::DIR_Y_DOWN, 0), // far corner
            mk(vliu_pkg::KIND_ENTER, 0, 5, 5, vliu_pkg::DIR_Y_DOWN, 0),     // enter while in game
            mk(vliu_pkg::KIND_ENTER, 1, 3, 4, vliu_pkg::DIR_Y_DOWN, 0),     // exactly on range
            mk(vliu_pkg::KIND_MOVE,  0, 0, 0, vliu_pkg::DIR_Y_DOWN, 32'hFFFFFFFF), // saturate at 0
            mk(vliu_pkg::KIND_MOVE,  0, 0, 0, vliu_pkg::DIR_X_DOWN, 32'h0),
            mk(vliu_pkg::KIND_MOVE,  31, 0, 0, vliu_pkg::DIR_X_UP, 32'hA5A5A5A5), // saturate at top
            mk(vliu_pkg::KIND_MOVE,  31, 0, 0, vliu_pkg::DIR_Y_UP, 32'h5A5A5A5A),
            mk(vliu_pkg::KIND_MOVE,  1, 0, 0, vliu_pkg::DIR_X_UP, 32'h12345678),   // leaves range
            mk(vliu_pkg::KIND_MOVE,  1, 0, 0, vliu_pkg::DIR_X_DOWN, 32'h9ABCDEF0), // back in range
            mk(vliu_pkg::KIND_ENTER, 2, 1, 1, vliu_pkg::DIR_Y_DOWN, 0),
            mk(vliu_pkg::KIND_LEAVE, 0, 0, 0, vliu_pkg::DIR_Y_DOWN, 0),
            mk(vliu_pkg::KIND_LEAVE, 31, 0, 0, vliu_pkg::DIR_Y_DOWN, 0),
            mk(vliu_pkg::KIND_LEAVE, 1, 0, 0, vliu_pkg::DIR_Y_DOWN, 0),
            mk(vliu_pkg::KIND_LEAVE, 2, 0, 0, vliu_pkg::DIR_Y_DOWN, 0)      // no one left
        };
        // first row with a result is readable at a glance: login to slot 0 at origin
        first_expected.push_back('{rcp: 5'd0, ntc: vliu_pkg::NTC_LOGIN, subj: 5'd0,
                                   px: 10'd0, py: 10'd0, st: 32'd0, last: 1'b1});
        foreach (directed_events[i])
        begin
            got_before = pending_notices.size();
            send_event(directed_events[i]);
            if (i == 3 && pending_notices.size() > got_before &&
                pending_notices[got_before] !== first_expected[0])
            begin
                $display("%0t: login prediction, expected %p, got %p", $time,
                         first_expected[0], pending_notices[got_before]);
                errors++;
            end
        end
        drain_notices();

        // random phases over several settings, extremes included
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin write_reg(vliu_pkg::CFG_WIDTH, 11'd16);
                         write_reg(vliu_pkg::CFG_HEIGHT, 11'd16);
                         write_reg(vliu_pkg::CFG_RANGE, 11'd4); end
                1: begin write_reg(vliu_pkg::CFG_WIDTH, 11'd0);
                         write_reg(vliu_pkg::CFG_HEIGHT, 11'd1);
                         write_reg(vliu_pkg::CFG_RANGE, 11'd0); end
                2: begin write_reg(vliu_pkg::CFG_WIDTH, 11'h7FF);
                         write_reg(vliu_pkg::CFG_HEIGHT, 11'd1024);
                         write_reg(vliu_pkg::CFG_RANGE, 11'd1023); end
                3: begin write_reg(vliu_pkg::CFG_WIDTH, 11'd6);
                         write_reg(vliu_pkg::CFG_HEIGHT, 11'd5);
                         write_reg(vliu_pkg::CFG_RANGE, 11'd2); end
                default: begin write_reg(vliu_pkg::CFG_WIDTH, 11'd1024);
                               write_reg(vliu_pkg::CFG_HEIGHT, 11'd13);
                               write_reg(vliu_pkg::CFG_RANGE, 11'd7); end
            endcase
            for (int k = 0; k < 46; k++)
            begin
                ev = rand_event(ph == 2 ? 32 : 12);
                // one long receiver hold-off while events keep coming
                if (ph == 0 && k == 20)
                begin
                    long_hold = 600;
                end
                send_event(ev);
            end
            drain_notices();
        end
        sending_done = 1'b1;

        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
